### hdl/spq_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and the ordering function for the sorted priority queue.
// No dependencies.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_id;
        logic [7:0]  task_priority;
        logic [15:0] task_arrival;
    } req_word_t;

    typedef struct packed {
        logic             accepted;
        logic [15:0]      out_id;
        logic [7:0]       out_priority;
        logic [15:0]      out_arrival;
        logic [15:0]      head_id;
        logic [7:0]       head_priority;
        logic [15:0]      head_arrival;
        logic [CNT_W-1:0] entry_count;
        logic             is_empty;
        logic             is_full;
    } rsp_word_t;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] arrival;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

    // a is served strictly before b
    function automatic logic ranks_before(entry_t a, entry_t b);
        logic r;
        if (a.prio != b.prio)
            r = a.prio < b.prio;
        else if (a.arrival != b.arrival)
            r = a.arrival < b.arrival;
        else
            r = a.id < b.id;
        return r;
    endfunction

endpackage

### hdl/spq_ctrl.sv
`timescale 1ns / 1ps
// Controller for the sorted priority queue: request handshake, sequencing
// and the result valid flag. Depends on spq_pkg.
module spq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output spq_pkg::dp_cmd_t cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic rsp_valid_reg, rsp_valid_next;
    logic slot_free;

    // result register can take a new word this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hdl/spq_datapath.sv
`timescale 1ns / 1ps
// Datapath for the sorted priority queue: request register, sorted slot row
// with per-slot compare, entry count and result register. Depends on spq_pkg.
module spq_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  spq_pkg::dp_cmd_t   cmd,
    input  spq_pkg::req_word_t req_word,
    output spq_pkg::rsp_word_t rsp_word
);
    import spq_pkg::*;

    req_word_t        req_reg;
    entry_t           slot_reg [DEPTH];
    entry_t           slot_next[DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    rsp_word_t        rsp_reg, rsp_next;

    entry_t           new_entry;
    logic [DEPTH-1:0] goes_here;
    logic             is_full_now, is_empty_now, do_ins, do_deq;

    assign new_entry.id      = req_reg.task_id;
    assign new_entry.prio    = req_reg.task_priority;
    assign new_entry.arrival = req_reg.task_arrival;

    assign is_full_now  = (count_reg == CNT_W'(DEPTH));
    assign is_empty_now = (count_reg == '0);
    assign do_ins = (req_reg.kind == KIND_INSERT) && !is_full_now;
    assign do_deq = (req_reg.kind == KIND_DEQUEUE) && !is_empty_now;

    // goes_here is set from the insert position up to the count; it is
    // monotone because the row is sorted
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CNT_W'(i) < count_reg)
                goes_here[i] = ranks_before(new_entry, slot_reg[i]);
            else
                goes_here[i] = (CNT_W'(i) == count_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (do_ins)
            begin
                if (i > 0 && goes_here[(i > 0) ? i - 1 : 0])
                    slot_next[i] = slot_reg[(i > 0) ? i - 1 : 0];
                else if (goes_here[i])
                    slot_next[i] = new_entry;
            end
            else if (do_deq && i < DEPTH - 1)
            begin
                slot_next[i] = slot_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_deq)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.accepted     = do_ins || do_deq;
        if (do_deq)
        begin
            rsp_next.out_id       = slot_reg[0].id;
            rsp_next.out_priority = slot_reg[0].prio;
            rsp_next.out_arrival  = slot_reg[0].arrival;
        end
        if (count_next != '0)
        begin
            rsp_next.head_id       = slot_next[0].id;
            rsp_next.head_priority = slot_next[0].prio;
            rsp_next.head_arrival  = slot_next[0].arrival;
        end
        rsp_next.entry_count = count_next;
        rsp_next.is_empty    = (count_next == '0);
        rsp_next.is_full     = (count_next == CNT_W'(DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.exec)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req_word;
        if (cmd.exec)
        begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < DEPTH; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    assign rsp_word = rsp_reg;

endmodule

### hdl/sorted_priority_queue.sv
`timescale 1ns / 1ps
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl, spq_datapath.
//
//   channel  handshake                payload               direction
//   req      req_valid / req_stall    req_word (req_word_t) into block
//   rsp      rsp_valid / rsp_stall    rsp_word (rsp_word_t) out of block
//
// Each word is first registered, then handled by a parallel compare-and-shift
// across all DEPTH slots that loads the result; no new request is taken meanwhile.
// A waiting result does not block the next request from being registered;
// its execute cycle waits until the result register is free.
// Reset (rst_n low, async) empties the queue and clears rsp_valid.
module sorted_priority_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  spq_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output spq_pkg::rsp_word_t rsp_word
);
    import spq_pkg::*;

    dp_cmd_t cmd;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    spq_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .rsp_word (rsp_word)
    );

endmodule
